// File: sv/spq_pkg.sv
package spq_pkg;

	// operation codes of a request item
	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_POP_HEAD = 2'd2;
	localparam logic [1:0] OP_POP_TAIL = 2'd3;

	// status codes of a response item
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// fixed field widths
	localparam int ID_W    = 8;
	localparam int PRI_W   = 8;
	localparam int AGE_W   = 16;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t e;
	} slot_t;

	// what a cell shows its neighbours
	typedef struct packed {
		slot_t s;
		logic  beats;
		logic  found;
	} link_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   shl;
		logic   all;
		logic   tail;
		entry_t item;
	} cmd_t;

endpackage

// File: sv/spq_if.sv
interface spq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  item_id;
	logic [7:0]  priority_req;
	logic [15:0] age;

	modport source (output valid, output operation, output item_id, output priority_req,
		output age, input ready);
	modport sink (input valid, input operation, input item_id, input priority_req,
		input age, output ready);
endinterface

interface spq_rsp_if;
	logic       valid;
	logic       ready;
	logic       head_valid;
	logic [7:0] head_id;
	logic [4:0] entry_count;
	logic [1:0] status;

	modport source (output valid, output head_valid, output head_id, output entry_count,
		output status, input ready);
	modport sink (input valid, input head_valid, input head_id, input entry_count,
		input status, output ready);
endinterface

// File: sv/spq_cell.sv
module spq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::cmd_t   cmd,
	input  spq_pkg::link_t  left,
	input  spq_pkg::link_t  right,
	output spq_pkg::link_t  here,
	output spq_pkg::slot_t  nxt
);

	spq_pkg::entry_t entry_q;
	logic            valid_q;
	logic            beats;
	logic            match;
	logic            shift;

	// new item goes in front of this slot (strictly higher key, or slot empty)
	assign beats = !valid_q || (entry_q.pri < cmd.item.pri) ||
		((entry_q.pri == cmd.item.pri) && (entry_q.age < cmd.item.age));
	assign match = valid_q && (entry_q.id == cmd.item.id);
	assign shift = cmd.all || left.found || match;

	assign here.s.valid = valid_q;
	assign here.s.e     = entry_q;
	assign here.beats   = beats;
	assign here.found   = left.found || match;

	always_comb begin
		nxt.valid = valid_q;
		nxt.e     = entry_q;
		if (cmd.ins) begin
			nxt.valid = valid_q || left.s.valid;
			if (beats && !left.beats) begin
				nxt.e = cmd.item;
			end else if (beats) begin
				nxt.e = left.s.e;
			end
		end else if (cmd.shl) begin
			if (shift) begin
				nxt.valid = right.s.valid;
				nxt.e     = right.s.e;
			end
		end else if (cmd.tail) begin
			nxt.valid = valid_q && right.s.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt.e;
	end

endmodule

// File: sv/sorted_priority_queue.sv
// Sorted priority queue of up to DEPTH entries, each an id, a priority and an
// age, held in a row of DEPTH cells in order of priority descending, then age
// descending; an entry inserted with a key equal to stored ones goes behind
// them. Operations: insert, remove the first entry with a given id, pop the
// head, pop the tail. Every request item gives exactly one response item with
// the head id, the entry count (low five bits) and a status. The operation is
// broadcast to all cells, which compare and shift against their neighbours in
// the same cycle, so one request can be taken every cycle; the response sits
// in an output register, and a new request is taken whenever that register is
// empty or being drained in the same cycle.
// No clearing pass is needed after reset.
module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	spq_req_if.sink      req,
	spq_rsp_if.source    rsp
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OUT_CW = spq_pkg::COUNT_W;

	spq_pkg::link_t  chain [DEPTH];
	spq_pkg::slot_t  nxt   [DEPTH];
	spq_pkg::link_t  left_edge;
	spq_pkg::link_t  right_edge;
	spq_pkg::cmd_t   cmd;

	logic             acc;
	logic             full;
	logic             empty;
	logic             found_any;
	logic [1:0]       status_nxt;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	logic                    rsp_valid_q;
	logic                    head_valid_q;
	logic [7:0]              head_id_q;
	logic [OUT_CW-1:0]       count_out_q;
	logic [1:0]              status_q;

	// output register free or being drained this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	// occupancy is read off the ends of the row
	assign full      = chain[DEPTH-1].s.valid;
	assign empty     = !chain[0].s.valid;
	assign found_any = chain[DEPTH-1].found;

	// row ends: nothing beats or matches ahead of the head, nothing behind the tail
	assign left_edge.s.valid  = 1'b1;
	assign left_edge.s.e      = '0;
	assign left_edge.beats    = 1'b0;
	assign left_edge.found    = 1'b0;
	assign right_edge.s.valid = 1'b0;
	assign right_edge.s.e     = '0;
	assign right_edge.beats   = 1'b1;
	assign right_edge.found   = 1'b0;

	assign cmd.item.id  = req.item_id;
	assign cmd.item.pri = req.priority_req;
	assign cmd.item.age = req.age;

	// decode the request; dropped or flagged operations leave the row alone
	always_comb begin
		cmd.ins    = 1'b0;
		cmd.shl    = 1'b0;
		cmd.all    = 1'b0;
		cmd.tail   = 1'b0;
		status_nxt = spq_pkg::ST_OK;
		unique case (req.operation)
			spq_pkg::OP_INSERT: begin
				cmd.ins    = acc && !full;
				status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end
			spq_pkg::OP_REMOVE: begin
				cmd.shl    = acc && found_any;
				status_nxt = found_any ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
			end
			spq_pkg::OP_POP_HEAD: begin
				cmd.shl    = acc && !empty;
				cmd.all    = 1'b1;
				status_nxt = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
			end
			spq_pkg::OP_POP_TAIL: begin
				cmd.tail   = acc && !empty;
				status_nxt = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
			end
			default: begin
				status_nxt = spq_pkg::ST_OK;
			end
		endcase
	end

	// the row of cells, each linked to both neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::link_t lft;
		spq_pkg::link_t rgt;
		if (i == 0) begin : g_first
			assign lft = left_edge;
		end else begin : g_mid_l
			assign lft = chain[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rgt = right_edge;
		end else begin : g_mid_r
			assign rgt = chain[i+1];
		end
		spq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (lft),
			.right  (rgt),
			.here   (chain[i]),
			.nxt    (nxt[i])
		);
	end

	// entry count follows the row, one up or one down
	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.shl || cmd.tail) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response item shows the row as it stands after the operation
	always_ff @(posedge clk) begin
		if (acc) begin
			head_valid_q <= nxt[0].valid;
			head_id_q    <= nxt[0].valid ? nxt[0].e.id : '0;
			count_out_q  <= OUT_CW'(count_nxt);
			status_q     <= status_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.head_valid  = head_valid_q;
	assign rsp.head_id     = head_id_q;
	assign rsp.entry_count = count_out_q;
	assign rsp.status      = status_q;

endmodule

// File: sv/spq_checker.sv
module spq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       head_valid,
	input logic [7:0] head_id,
	input logic [4:0] entry_count,
	input logic [1:0] status
);

	// a stalled response item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(head_id) &&
		$stable(entry_count) && $stable(status) && $stable(head_valid))
		else $error("response item changed while stalled");

	// every accepted request gives a response in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after accepted request");

	// requests are taken whenever the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty output");

	// an empty pop leaves an empty queue
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == spq_pkg::ST_EMPTY) |-> !head_valid && (head_id == 8'd0))
		else $error("empty pop reports a head");

	// a dropped insert means the queue is full, so it has a head
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == spq_pkg::ST_FULL) |-> head_valid)
		else $error("full status without a head");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.head_valid  (rsp.head_valid),
	.head_id     (rsp.head_id),
	.entry_count (rsp.entry_count),
	.status      (rsp.status)
);

// File: test/spq_response_check.sv
module spq_response_check #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	typedef struct packed {
		logic               head_valid;
		logic [ID_W-1:0]    head_id;
		logic [COUNT_W-1:0] entry_count;
		logic [STAT_W-1:0]  status;
	} head_report_t;

	// own copy of the sorted row, slots 0 to held-1 in use
	entry_t       row [DEPTH];
	int           held = 0;
	head_report_t due_reports[$];

	function automatic head_report_t queue_step(input logic [OP_W-1:0] op, input entry_t item);
		head_report_t r;
		int           pos;
		int           i;
		r.status = ST_OK;
		pos = -1;
		case (op)
			OP_INSERT: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// first slot with a strictly lower key, so equal keys stay ahead
					pos = held;
					for (i = held - 1; i >= 0; i--)
						if (row[i].pri < item.pri ||
								(row[i].pri == item.pri && row[i].age < item.age))
							pos = i;
					for (i = held; i > pos; i--)
						row[i] = row[i-1];
					row[pos] = item;
					held++;
				end
			end
			OP_REMOVE: begin
				for (i = held - 1; i >= 0; i--)
					if (row[i].id == item.id)
						pos = i;
				if (pos < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (i = pos; i < held - 1; i++)
						row[i] = row[i+1];
					held--;
				end
			end
			default: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == OP_POP_HEAD)
						for (i = 0; i < held - 1; i++)
							row[i] = row[i+1];
					held--;
				end
			end
		endcase
		r.head_valid  = (held > 0);
		r.head_id     = (held > 0) ? row[0].id : '0;
		r.entry_count = COUNT_W'(held);
		return r;
	endfunction

	always @(posedge clk) begin
		head_report_t got;
		head_report_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.head_valid, rsp.head_id, rsp.entry_count, rsp.status};
				if (due_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected response hv=%0d id=%0d cnt=%0d st=%0d", $time,
							got.head_valid, got.head_id, got.entry_count, got.status);
				end else begin
					want = due_reports.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch expected hv=%0d id=%0d cnt=%0d st=%0d, got hv=%0d id=%0d cnt=%0d st=%0d",
								$time, want.head_valid, want.head_id, want.entry_count,
								want.status, got.head_valid, got.head_id, got.entry_count,
								got.status);
					end
				end
			end
			if (req.valid && req.ready)
				due_reports.push_back(queue_step(req.operation,
					{req.item_id, req.priority_req, req.age}));
			outstanding = due_reports.size();
		end
	end

endmodule

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int DEPTH = 16;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   outstanding;

	// idling switch shared by both sides, off for one long stretch
	logic idle_on = 1'b1;
	// each bump asks the receiver for one long hold-off
	int   hold_asked = 0;

	spq_req_if req_bus ();
	spq_rsp_if rsp_bus ();

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	spq_response_check #(
		.DEPTH(DEPTH)
	) i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// present one item at the falling edge and hold it until taken,
	// returning at the falling edge after acceptance
	task automatic offer(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, input logic [AGE_W-1:0] age);
		while (idle_on && $urandom_range(99) < 13) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.operation    <= op;
		req_bus.item_id      <= id;
		req_bus.priority_req <= pri;
		req_bus.age          <= age;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random back-pressure, plus a long hold-off counted here on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= !(idle_on && $urandom_range(99) < 13);
			end
		end
	end

	// sender and verdict
	initial begin
		logic [OP_W-1:0]  op;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic [AGE_W-1:0] age;
		int               ins_pct;
		int               k;
		req_bus.valid        = 1'b0;
		req_bus.operation    = OP_INSERT;
		req_bus.item_id      = '0;
		req_bus.priority_req = '0;
		req_bus.age          = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue: both pops and a remove are flagged
		offer(OP_POP_HEAD, 8'h00, 8'h00, 16'h0000);
		offer(OP_POP_TAIL, 8'hFF, 8'hFF, 16'hFFFF);
		offer(OP_REMOVE,   8'h00, 8'h00, 16'h0000);

		// fill to the brim with extreme keys, equal keys and a repeated id
		offer(OP_INSERT, 8'h10, 8'd100, 16'd500);
		offer(OP_INSERT, 8'hFF, 8'd255, 16'hFFFF);
		offer(OP_INSERT, 8'h00, 8'd0,   16'h0000);
		offer(OP_INSERT, 8'h11, 8'd100, 16'd500);   // equal key goes behind
		offer(OP_INSERT, 8'h12, 8'd100, 16'd501);   // higher age goes ahead
		offer(OP_INSERT, 8'h13, 8'd100, 16'd499);
		offer(OP_INSERT, 8'hFE, 8'd255, 16'hFFFF);  // ties with the head
		offer(OP_INSERT, 8'h10, 8'd7,   16'd7);     // same id as an earlier entry
		offer(OP_INSERT, 8'h55, 8'hAA,  16'h5555);
		offer(OP_INSERT, 8'hAA, 8'h55,  16'hAAAA);
		offer(OP_INSERT, 8'h01, 8'd0,   16'hFFFF);
		offer(OP_INSERT, 8'h02, 8'd255, 16'h0000);
		offer(OP_INSERT, 8'h03, 8'd1,   16'd1);
		offer(OP_INSERT, 8'h04, 8'd254, 16'd65534);
		offer(OP_INSERT, 8'h05, 8'd128, 16'd32768);
		offer(OP_INSERT, 8'h06, 8'd127, 16'd32767);
		// queue full now, this one is dropped
		offer(OP_INSERT, 8'h07, 8'd200, 16'd200);
		// first of two matching ids goes, then a miss
		offer(OP_REMOVE, 8'h10, 8'd0, 16'd0);
		offer(OP_REMOVE, 8'h99, 8'd0, 16'd0);
		offer(OP_POP_HEAD, 8'h00, 8'd0, 16'd0);
		offer(OP_POP_TAIL, 8'h00, 8'd0, 16'd0);

		// random part: alternate filling and draining phases so the queue
		// swings between full and empty; small id and key ranges make
		// removes hit and keys tie
		for (int n = 0; n < 1925; n++) begin
			if (n == 200 || n == 1300)
				hold_asked++;
			idle_on = !(n >= 700 && n < 1000);
			if (n == 1000) begin
				// sender pause until the block has answered everything
				req_bus.valid <= 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			ins_pct = ((n / 64) % 2 == 0) ? 65 : 20;
			if ($urandom_range(99) < ins_pct) begin
				op = OP_INSERT;
			end else begin
				k = $urandom_range(2);
				op = (k == 0) ? OP_REMOVE : (k == 1) ? OP_POP_HEAD : OP_POP_TAIL;
			end
			id  = ($urandom_range(99) < 75) ? ID_W'($urandom_range(15)) :
				ID_W'($urandom_range(255));
			pri = ($urandom_range(1) == 0) ? PRI_W'($urandom_range(3)) :
				PRI_W'($urandom_range(255));
			age = ($urandom_range(1) == 0) ? AGE_W'($urandom_range(3)) :
				AGE_W'($urandom_range(65535));
			offer(op, id, pri, age);
		end

		// drain and let the output register settle
		req_bus.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#3ms;
		$display("tb: errors");
		$finish;
	end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
test/spq_response_check.sv
test/tb.sv
